### sv/ocb_pkg.sv
// Shared types and constants for the character-cell display store.
// Holds command and result codes, controller states and the control/status bundles.
// No dependencies.
`default_nettype none

package ocb_pkg;

    // Default store geometry
    localparam int OCB_MAX_COLS  = 60;
    localparam int OCB_MAX_ROWS  = 22;
    localparam int OCB_PAGE_BITS = 2;

    // Configuration register reset values
    localparam logic [5:0] LW_RESET    = 6'd30;
    localparam logic [7:0] BLANK_RESET = 8'd32;

    // Configuration register indexes
    localparam int         CFG_IDX_W      = 1;
    localparam logic [0:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [0:0] CFG_BLANK_CODE = 1'b1;

    // Input commands
    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_READ    = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_REFRESH = 3'd3,
        CMD_DRAW    = 3'd4
    } t_cmd;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_READ   = 3'd0,
        KIND_RUN    = 3'd1,
        KIND_CLEAR  = 3'd2,
        KIND_COMMIT = 3'd3,
        KIND_NONE   = 3'd4
    } t_kind;

    // Cell memory write data select
    typedef enum logic [2:0] {
        WR_RESET,
        WR_BLANK,
        WR_CELL,
        WR_MARK,
        WR_UNMARK
    } t_wr_sel;

    // Controller states
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_WR_RD,
        S_WR_CHK,
        S_RD_RD,
        S_RD_EMIT,
        S_NONE_EMIT,
        S_CLR,
        S_RF_RD,
        S_RF_CHK,
        S_CLR_EMIT,
        S_DR_RD,
        S_DR_CHK,
        S_DR_END,
        S_RUN_WR,
        S_RUN_RD,
        S_RUN_CHK,
        S_RUN_LAST
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    take;
        logic    rd_en;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    pos_step;
        logic    found;
        logic    cur_next;
        logic    out_load;
        t_kind   out_kind;
        logic    out_last;
        logic    set_cleared;
        logic    clr_flags;
    } t_ctrl;

    // Status from datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic in_hit;
        logic pos_last;
        logic rd_dirty;
        logic wr_differs;
        logic rf_differs;
        logic run_stop;
        logic run_match;
        logic out_free;
        logic flags_any;
    } t_stat;

endpackage

`default_nettype wire

### sv/ocb_ctrl.sv
// Sequencer for the character-cell display store.
// Walks the cell memory for sweeps, scans and runs; drives the datapath commands.
// Depends on ocb_pkg.
`default_nettype none

module ocb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ocb_pkg::t_stat i_stat,
    output ocb_pkg::t_ctrl     o_ctrl
);

    ocb_pkg::t_state r_state;
    ocb_pkg::t_state n_state;

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ocb_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ocb_pkg::S_INIT: begin
                if (i_stat.pos_last) n_state = ocb_pkg::S_IDLE;
            end
            ocb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_stat.cmd)
                        ocb_pkg::CMD_WRITE:
                            n_state = i_stat.in_hit ? ocb_pkg::S_WR_RD : ocb_pkg::S_IDLE;
                        ocb_pkg::CMD_READ:
                            n_state = i_stat.in_hit ? ocb_pkg::S_RD_RD : ocb_pkg::S_NONE_EMIT;
                        ocb_pkg::CMD_CLEAR:   n_state = ocb_pkg::S_CLR;
                        ocb_pkg::CMD_REFRESH: n_state = ocb_pkg::S_RF_RD;
                        ocb_pkg::CMD_DRAW:    n_state = ocb_pkg::S_DR_RD;
                        default:              n_state = ocb_pkg::S_IDLE;
                    endcase
                end
            end
            ocb_pkg::S_WR_RD:  n_state = ocb_pkg::S_WR_CHK;
            ocb_pkg::S_WR_CHK: n_state = ocb_pkg::S_IDLE;
            ocb_pkg::S_RD_RD:  n_state = ocb_pkg::S_RD_EMIT;
            ocb_pkg::S_RD_EMIT, ocb_pkg::S_NONE_EMIT, ocb_pkg::S_CLR_EMIT,
            ocb_pkg::S_DR_END, ocb_pkg::S_RUN_LAST: begin
                if (i_stat.out_free) n_state = ocb_pkg::S_IDLE;
            end
            ocb_pkg::S_CLR: begin
                if (i_stat.pos_last) n_state = ocb_pkg::S_CLR_EMIT;
            end
            ocb_pkg::S_RF_RD: n_state = ocb_pkg::S_RF_CHK;
            ocb_pkg::S_RF_CHK: begin
                n_state = i_stat.pos_last ? ocb_pkg::S_CLR_EMIT : ocb_pkg::S_RF_RD;
            end
            ocb_pkg::S_DR_RD: n_state = ocb_pkg::S_DR_CHK;
            ocb_pkg::S_DR_CHK: begin
                priority if (i_stat.rd_dirty) n_state = ocb_pkg::S_RUN_WR;
                else if (i_stat.pos_last)     n_state = ocb_pkg::S_DR_END;
                else                          n_state = ocb_pkg::S_DR_RD;
            end
            ocb_pkg::S_RUN_WR: begin
                n_state = i_stat.run_stop ? ocb_pkg::S_RUN_LAST : ocb_pkg::S_RUN_RD;
            end
            ocb_pkg::S_RUN_RD: n_state = ocb_pkg::S_RUN_CHK;
            ocb_pkg::S_RUN_CHK: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.run_match ? ocb_pkg::S_RUN_WR : ocb_pkg::S_IDLE;
                end
            end
            default: n_state = ocb_pkg::S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_in_ready = 1'b0;
        o_ctrl     = '0;
        unique case (r_state)
            ocb_pkg::S_INIT: begin
                o_ctrl.wr_en    = 1'b1;
                o_ctrl.wr_sel   = ocb_pkg::WR_RESET;
                o_ctrl.pos_step = 1'b1;
            end
            ocb_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.take = i_in_valid;
            end
            ocb_pkg::S_WR_RD, ocb_pkg::S_RD_RD, ocb_pkg::S_RF_RD,
            ocb_pkg::S_DR_RD, ocb_pkg::S_RUN_RD: begin
                o_ctrl.rd_en = 1'b1;
            end
            ocb_pkg::S_WR_CHK: begin
                o_ctrl.wr_en  = i_stat.wr_differs;
                o_ctrl.wr_sel = ocb_pkg::WR_CELL;
            end
            ocb_pkg::S_RD_EMIT: begin
                o_ctrl.out_load = i_stat.out_free;
                o_ctrl.out_kind = ocb_pkg::KIND_READ;
                o_ctrl.out_last = 1'b1;
            end
            ocb_pkg::S_NONE_EMIT: begin
                o_ctrl.out_load = i_stat.out_free;
                o_ctrl.out_kind = ocb_pkg::KIND_NONE;
                o_ctrl.out_last = 1'b1;
            end
            ocb_pkg::S_CLR: begin
                o_ctrl.wr_en       = 1'b1;
                o_ctrl.wr_sel      = ocb_pkg::WR_BLANK;
                o_ctrl.pos_step    = 1'b1;
                o_ctrl.set_cleared = 1'b1;
            end
            ocb_pkg::S_RF_CHK: begin
                o_ctrl.wr_en    = i_stat.rf_differs;
                o_ctrl.wr_sel   = ocb_pkg::WR_MARK;
                o_ctrl.pos_step = 1'b1;
            end
            ocb_pkg::S_CLR_EMIT: begin
                o_ctrl.out_load = i_stat.out_free;
                o_ctrl.out_kind = ocb_pkg::KIND_CLEAR;
                o_ctrl.out_last = 1'b1;
            end
            ocb_pkg::S_DR_CHK: begin
                o_ctrl.found    = i_stat.rd_dirty;
                o_ctrl.pos_step = !i_stat.rd_dirty;
            end
            ocb_pkg::S_DR_END: begin
                o_ctrl.out_load  = i_stat.out_free;
                o_ctrl.out_kind  = i_stat.flags_any ? ocb_pkg::KIND_COMMIT
                                                    : ocb_pkg::KIND_NONE;
                o_ctrl.out_last  = 1'b1;
                o_ctrl.clr_flags = i_stat.out_free;
            end
            ocb_pkg::S_RUN_WR: begin
                o_ctrl.wr_en    = 1'b1;
                o_ctrl.wr_sel   = ocb_pkg::WR_UNMARK;
                o_ctrl.pos_step = 1'b1;
            end
            ocb_pkg::S_RUN_CHK: begin
                o_ctrl.out_load = i_stat.out_free;
                o_ctrl.out_kind = ocb_pkg::KIND_RUN;
                o_ctrl.out_last = !i_stat.run_match;
                o_ctrl.cur_next = i_stat.out_free && i_stat.run_match;
            end
            ocb_pkg::S_RUN_LAST: begin
                o_ctrl.out_load = i_stat.out_free;
                o_ctrl.out_kind = ocb_pkg::KIND_RUN;
                o_ctrl.out_last = 1'b1;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/ocb_dp.sv
// Datapath for the character-cell display store: cell memory, cell position,
// configuration and flag registers, run tracking and the output register.
// Depends on ocb_pkg.
`default_nettype none

module ocb_dp #(
    parameter int MAX_COLS  = ocb_pkg::OCB_MAX_COLS,
    parameter int MAX_ROWS  = ocb_pkg::OCB_MAX_ROWS,
    parameter int PAGE_BITS = ocb_pkg::OCB_PAGE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ocb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]                    i_cfg_data,
    input  wire logic [2:0]                    i_cmd,
    input  wire logic [4:0]                    i_row,
    input  wire logic [5:0]                    i_col,
    input  wire logic [7:0]                    i_char_code,
    input  wire logic [1:0]                    i_page,
    input  wire logic                          i_blink,
    input  wire ocb_pkg::t_ctrl                i_ctrl,
    output ocb_pkg::t_stat                     o_stat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_kind,
    output logic [4:0]                         o_out_row,
    output logic [5:0]                         o_out_col,
    output logic [7:0]                         o_out_code,
    output logic [1:0]                         o_out_page,
    output logic                               o_out_blink,
    output logic                               o_last
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int AW    = ROW_W + COL_W;
    localparam int DEPTH = MAX_ROWS * (1 << COL_W);
    localparam int MW    = PAGE_BITS + 10;
    localparam int NC_W  = ((COL_W > 6) ? COL_W : 6) + 1;

    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS - 1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLS - 1);

    // Configuration and flags
    logic [5:0] r_line_width;
    logic [7:0] r_blank;
    logic       r_cleared;
    logic       r_sent;

    // Cell position
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [AW-1:0]    w_addr;

    // Latched input word
    logic [7:0]           r_code_in;
    logic [PAGE_BITS-1:0] r_page_in;
    logic                 r_blink_in;

    // Run being drawn
    logic [ROW_W-1:0]     r_run_row;
    logic [COL_W-1:0]     r_run_col;
    logic [PAGE_BITS-1:0] r_run_page;
    logic                 r_run_blink;
    logic [7:0]           r_cur_code;

    // Cell memory: {dirty, blink, page, code}
    logic [MW-1:0]        r_mem [0:DEPTH-1];
    logic [MW-1:0]        r_rd_word;
    logic [MW-1:0]        w_wr_word;
    logic                 w_rd_dirty;
    logic                 w_rd_blink;
    logic [PAGE_BITS-1:0] w_rd_page;
    logic [7:0]           w_rd_code;

    logic [NC_W-1:0] w_next_col;
    logic            w_pos_last;
    logic            w_out_free;
    logic            w_load_in_pos;

    assign w_addr     = {r_row, r_col};
    assign w_rd_dirty = r_rd_word[MW-1];
    assign w_rd_blink = r_rd_word[MW-2];
    assign w_rd_page  = r_rd_word[8 +: PAGE_BITS];
    assign w_rd_code  = r_rd_word[7:0];
    assign w_pos_last = (r_row == ROW_MAX) && (r_col == COL_MAX);
    assign w_next_col = NC_W'(r_col) + NC_W'(1);
    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_load_in_pos = (ocb_pkg::t_cmd'(i_cmd) == ocb_pkg::CMD_WRITE) ||
                           (ocb_pkg::t_cmd'(i_cmd) == ocb_pkg::CMD_READ);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= ocb_pkg::LW_RESET;
            r_blank      <= ocb_pkg::BLANK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ocb_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data[5:0];
                ocb_pkg::CFG_BLANK_CODE: r_blank      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clear-pending and sent-since-commit flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cleared <= 1'b0;
            r_sent    <= 1'b0;
        end else begin
            if (i_ctrl.set_cleared) r_cleared <= 1'b1;
            if (i_ctrl.found)       r_sent    <= 1'b1;
            if (i_ctrl.clr_flags) begin
                r_cleared <= 1'b0;
                r_sent    <= 1'b0;
            end
        end
    end

    // Load or advance the cell position in row-major order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_ctrl.take) begin
            r_row <= w_load_in_pos ? ROW_W'(i_row) : '0;
            r_col <= w_load_in_pos ? COL_W'(i_col) : '0;
        end else if (i_ctrl.pos_step) begin
            if (r_col == COL_MAX) begin
                r_col <= '0;
                r_row <= (r_row == ROW_MAX) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Hold the input word and the run attributes
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_code_in  <= i_char_code;
            r_page_in  <= PAGE_BITS'(i_page);
            r_blink_in <= i_blink;
        end
        if (i_ctrl.found) begin
            r_run_row   <= r_row;
            r_run_col   <= r_col;
            r_run_page  <= w_rd_page;
            r_run_blink <= w_rd_blink;
        end
        if (i_ctrl.found || i_ctrl.cur_next) begin
            r_cur_code <= w_rd_code;
        end
    end

    // Select memory write data
    always_comb begin
        unique case (i_ctrl.wr_sel)
            ocb_pkg::WR_RESET:  w_wr_word = {2'b00, PAGE_BITS'(0), ocb_pkg::BLANK_RESET};
            ocb_pkg::WR_BLANK:  w_wr_word = {2'b00, PAGE_BITS'(0), r_blank};
            ocb_pkg::WR_CELL:   w_wr_word = {1'b1, r_blink_in, r_page_in, r_code_in};
            ocb_pkg::WR_MARK:   w_wr_word = {1'b1, r_rd_word[MW-2:0]};
            ocb_pkg::WR_UNMARK: w_wr_word = {1'b0, r_run_blink, r_run_page, r_cur_code};
            default:            w_wr_word = {2'b00, PAGE_BITS'(0), r_blank};
        endcase
    end

    // Cell memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) r_mem[w_addr] <= w_wr_word;
        if (i_ctrl.rd_en) r_rd_word     <= r_mem[w_addr];
    end

    // Status back to the controller
    always_comb begin
        o_stat.cmd        = ocb_pkg::t_cmd'(i_cmd);
        o_stat.in_hit     = (6'(i_row) < 6'(MAX_ROWS)) && (7'(i_col) < 7'(MAX_COLS));
        o_stat.pos_last   = w_pos_last;
        o_stat.rd_dirty   = w_rd_dirty;
        o_stat.wr_differs = (w_rd_code != r_code_in) || (w_rd_page != r_page_in);
        o_stat.rf_differs = (w_rd_code != r_blank);
        o_stat.run_stop   = (w_next_col >= NC_W'(r_line_width)) || (r_col == COL_MAX);
        o_stat.run_match  = w_rd_dirty && (w_rd_page == r_run_page) &&
                            (w_rd_blink == r_run_blink);
        o_stat.out_free   = w_out_free;
        o_stat.flags_any  = r_cleared || r_sent;
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            o_kind <= i_ctrl.out_kind;
            o_last <= i_ctrl.out_last;
            unique case (i_ctrl.out_kind)
                ocb_pkg::KIND_READ: begin
                    o_out_row   <= 5'(r_row);
                    o_out_col   <= 6'(r_col);
                    o_out_code  <= w_rd_code;
                    o_out_page  <= 2'(w_rd_page);
                    o_out_blink <= 1'b0;
                end
                ocb_pkg::KIND_RUN: begin
                    o_out_row   <= 5'(r_run_row);
                    o_out_col   <= 6'(r_run_col);
                    o_out_code  <= r_cur_code;
                    o_out_page  <= 2'(r_run_page);
                    o_out_blink <= r_run_blink;
                end
                default: begin
                    o_out_row   <= '0;
                    o_out_col   <= '0;
                    o_out_code  <= '0;
                    o_out_page  <= '0;
                    o_out_blink <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/osd_char_buffer_dirty_runs.sv
// Character-cell display store with dirty marks; one cell memory port sets the pace.
// Write: read, check (none out of range). Read: read, emit (only emit out of range), plus
// output wait. Clear: one cycle per cell (MAX_ROWS*MAX_COLS), then the result; refresh:
// read, check per cell. Draw step: read, check per cell scanned to the first dirty cell,
// then write, read, check per run cell; write, emit at the line width. Reset: synchronous;
// clearing all cells (1320 by default) holds the input off. Uses ocb_pkg/ctrl/dp.
`default_nettype none

module osd_char_buffer_dirty_runs #(
    parameter int MAX_COLS  = ocb_pkg::OCB_MAX_COLS,
    parameter int MAX_ROWS  = ocb_pkg::OCB_MAX_ROWS,
    parameter int PAGE_BITS = ocb_pkg::OCB_PAGE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ocb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]                    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_cmd,
    input  wire logic [4:0]                    i_row,
    input  wire logic [5:0]                    i_col,
    input  wire logic [7:0]                    i_char_code,
    input  wire logic [1:0]                    i_page,
    input  wire logic                          i_blink,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_kind,
    output logic [4:0]                         o_out_row,
    output logic [5:0]                         o_out_col,
    output logic [7:0]                         o_out_code,
    output logic [1:0]                         o_out_page,
    output logic                               o_out_blink,
    output logic                               o_last
);

    ocb_pkg::t_ctrl w_ctrl;
    ocb_pkg::t_stat w_stat;

    // Sequencer
    ocb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    // Cell store and output register
    ocb_dp #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_char_code (i_char_code),
        .i_page      (i_page),
        .i_blink     (i_blink),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_code  (o_out_code),
        .o_out_page  (o_out_page),
        .o_out_blink (o_out_blink),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
